[src/imrot_pkg.sv]
// Shared constants and types for the nearest-neighbor image rotation block.
// Field widths, register indexes, operation codes and fixed-point constants.
// No dependencies.
package imrot_pkg;

    // Port field widths
    localparam int COORD_W     = 7;
    localparam int PIXEL_W     = 32;
    localparam int SIZE_W      = 8;
    localparam int TRIG_W      = 16;
    localparam int CROP_POS_W  = 6;
    localparam int CROP_DIM_W  = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed-point layout: Q2.14 trig values, Q14 corners, Q28 products
    localparam int Q14_FRAC = 14;
    localparam int Q28_FRAC = 28;

    // Default source store geometry
    localparam int SOURCE_WIDTH_DEF  = 64;
    localparam int SOURCE_HEIGHT_DEF = 64;

    // Transparent magenta returned outside the crop region
    localparam logic [PIXEL_W-1:0] FILL_PIXEL = 32'h00FF_00FF;

    // Saturation limit of the rotated bounding box
    localparam logic [SIZE_W-1:0] BOX_MAX = 8'd128;

    // Configuration reset values
    localparam logic signed [TRIG_W-1:0]  COSINE_RST      = 16'sd16384;
    localparam logic signed [TRIG_W-1:0]  SINE_RST        = 16'sd0;
    localparam logic [CROP_POS_W-1:0]     CROP_LEFT_RST   = 6'd0;
    localparam logic [CROP_POS_W-1:0]     CROP_TOP_RST    = 6'd0;
    localparam logic [CROP_DIM_W-1:0]     CROP_WIDTH_RST  = 7'd64;
    localparam logic [CROP_DIM_W-1:0]     CROP_HEIGHT_RST = 7'd64;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COSINE,
        REG_SINE,
        REG_CROP_LEFT,
        REG_CROP_TOP,
        REG_CROP_WIDTH,
        REG_CROP_HEIGHT
    } cfg_reg_t;

    // Input operation codes
    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } op_t;

endpackage

[src/image_rotate_nearest.sv]
// Nearest-neighbor rotation of a cropped source image by inverse mapping.
// Holds the configuration registers, the mapping pipeline and the source store.
// Depends on imrot_pkg.
//
//  Channel   Handshake             Payload                                   Dir
//  --------  --------------------  ----------------------------------------  ---
//  in        in_valid / in_ready   op, coord_x, coord_y, pixel_in            in
//  out       out_valid / out_ready pixel_out, inside_res, rotated_width,     out
//                                  rotated_height
//  cfg       cfg_write             cfg_index, cfg_data                       in
//
// One item enters per cycle while in_ready is high. A query passes the input, box, size,
// multiply, sum, divide, check, address and RED_STEPS stages into the output register;
// RED_STEPS is the number of compare-subtract stages that wrap the linear store address.
// Loads write the store in the stage before the output register and give no result.
// Reset clears the valid bits and the configuration; the store is not cleared.
// Each stage stalls only while it is full and the stage after it cannot take
// its item, so bubbles close up and in_ready stays high while any stage is empty.
module image_rotate_nearest #(
    parameter int SOURCE_WIDTH  = imrot_pkg::SOURCE_WIDTH_DEF,
    parameter int SOURCE_HEIGHT = imrot_pkg::SOURCE_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [imrot_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [imrot_pkg::COORD_W-1:0]       coord_x,
    input  logic [imrot_pkg::COORD_W-1:0]       coord_y,
    input  logic [imrot_pkg::PIXEL_W-1:0]       pixel_in,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [imrot_pkg::PIXEL_W-1:0]       pixel_out,
    output logic                                inside_res,
    output logic [imrot_pkg::SIZE_W-1:0]        rotated_width,
    output logic [imrot_pkg::SIZE_W-1:0]        rotated_height
);
    import imrot_pkg::*;

    // Store geometry and address reduction
    localparam int STORE_DEPTH = SOURCE_WIDTH * SOURCE_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    // column and row of a query stay at or below 190 before wrapping
    localparam int ADDR_BOUND  = 190 + 190 * SOURCE_WIDTH;
    localparam int RW          = $clog2(ADDR_BOUND + STORE_DEPTH + 1);
    localparam int RED_QUOT    = ADDR_BOUND / STORE_DEPTH;
    localparam int RED_RAW     = $clog2(RED_QUOT + 1);
    localparam int RED_STEPS   = (RED_RAW < 1) ? 1 : RED_RAW;

    // Datapath widths
    localparam int PCFG_W = CROP_DIM_W + 1 + TRIG_W;   // crop size times trig
    localparam int CRN_W  = PCFG_W + 1;                // corners and mapped point
    localparam int PRD_W  = CRN_W + TRIG_W;            // point times trig
    localparam int SUM_W  = PRD_W + 1;
    localparam int SRC_W  = SUM_W - Q28_FRAC;          // source coordinate

    localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << Q28_FRAC) - 64'd1);
    localparam logic [CRN_W:0]          CEIL_BIAS  = (CRN_W + 1)'((1 << Q14_FRAC) - 1);

    // Stage indexes
    localparam int ST_IN   = 0;
    localparam int ST_BOX  = 1;
    localparam int ST_SIZE = 2;
    localparam int ST_MUL  = 3;
    localparam int ST_SUM  = 4;
    localparam int ST_DIV  = 5;
    localparam int ST_CHK  = 6;
    localparam int ST_ADDR = 7;
    localparam int ST_RED0 = 8;
    localparam int ST_LAST = ST_RED0 + RED_STEPS;
    localparam int NUM_ST  = ST_LAST + 1;

    typedef struct packed {
        logic                       op;
        logic [COORD_W-1:0]         cx;
        logic [COORD_W-1:0]         cy;
        logic [PIXEL_W-1:0]         pix;
        logic                       ld_ok;
        logic signed [PCFG_W-1:0]   wc;
        logic signed [PCFG_W-1:0]   ws;
        logic signed [PCFG_W-1:0]   hs;
        logic signed [PCFG_W-1:0]   hc;
        logic signed [CRN_W-1:0]    min_x;
        logic signed [CRN_W-1:0]    max_x;
        logic signed [CRN_W-1:0]    min_y;
        logic signed [CRN_W-1:0]    max_y;
        logic [SIZE_W-1:0]          rw;
        logic [SIZE_W-1:0]          rh;
        logic signed [CRN_W-1:0]    pos_x;
        logic signed [CRN_W-1:0]    pos_y;
        logic                       inbox;
        logic signed [PRD_W-1:0]    xc;
        logic signed [PRD_W-1:0]    ys;
        logic signed [PRD_W-1:0]    yc;
        logic signed [PRD_W-1:0]    xs;
        logic signed [SUM_W-1:0]    num_x;
        logic signed [SUM_W-1:0]    num_y;
        logic signed [SRC_W-1:0]    src_x;
        logic signed [SRC_W-1:0]    src_y;
        logic                       in_crop;
        logic [SIZE_W-1:0]          col;
        logic [SIZE_W-1:0]          row;
        logic [RW-1:0]              addr;
    } item_t;

    // Configuration registers
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic [CROP_POS_W-1:0]     crop_left_reg;
    logic [CROP_POS_W-1:0]     crop_top_reg;
    logic [CROP_DIM_W-1:0]     crop_width_reg;
    logic [CROP_DIM_W-1:0]     crop_height_reg;

    // Pipeline state
    item_t              pipe_reg  [NUM_ST];
    item_t              pipe_next [NUM_ST];
    logic [NUM_ST-1:0]  valid_reg;
    logic [NUM_ST-1:0]  valid_next;
    logic [NUM_ST-1:0]  stage_en;

    // Source store
    logic [PIXEL_W-1:0] store_mem [STORE_DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               mem_move;

    function automatic logic signed [CRN_W-1:0] min2(
        input logic signed [CRN_W-1:0] a,
        input logic signed [CRN_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CRN_W-1:0] max2(
        input logic signed [CRN_W-1:0] a,
        input logic signed [CRN_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg         <= COSINE_RST;
            sin_reg         <= SINE_RST;
            crop_left_reg   <= CROP_LEFT_RST;
            crop_top_reg    <= CROP_TOP_RST;
            crop_width_reg  <= CROP_WIDTH_RST;
            crop_height_reg <= CROP_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COSINE:      cos_reg         <= signed'(cfg_data);
                REG_SINE:        sin_reg         <= signed'(cfg_data);
                REG_CROP_LEFT:   crop_left_reg   <= cfg_data[CROP_POS_W-1:0];
                REG_CROP_TOP:    crop_top_reg    <= cfg_data[CROP_POS_W-1:0];
                REG_CROP_WIDTH:  crop_width_reg  <= cfg_data[CROP_DIM_W-1:0];
                REG_CROP_HEIGHT: crop_height_reg <= cfg_data[CROP_DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // Advance a stage when it is empty or the next stage advances
    always_comb
    begin
        stage_en[ST_LAST] = !valid_reg[ST_LAST] || out_ready;
        for (int k = ST_LAST - 1; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    assign in_ready = stage_en[ST_IN];

    // Carry valid bits with the data; drop loads before the output stage
    always_comb
    begin
        valid_next[ST_IN] = in_valid;
        for (int k = 1; k < ST_LAST; k++)
        begin
            valid_next[k] = valid_reg[k - 1];
        end
        valid_next[ST_LAST] = valid_reg[ST_LAST - 1] && (pipe_reg[ST_LAST - 1].op == OP_QUERY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_ST; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // Stage logic
    always_comb
    begin
        item_t                      nx;
        logic signed [CRN_W-1:0]    x2;
        logic signed [CRN_W-1:0]    x3;
        logic signed [CRN_W-1:0]    y1;
        logic signed [CRN_W-1:0]    y2;
        logic signed [CRN_W-1:0]    y3;
        logic [CRN_W:0]             span_x;
        logic [CRN_W:0]             span_y;
        logic [CRN_W:0]             ceil_x;
        logic [CRN_W:0]             ceil_y;
        logic signed [SUM_W-1:0]    bias_x;
        logic signed [SUM_W-1:0]    bias_y;
        logic [RW-1:0]              red_sub;

        // capture the item, crop-size products and the load address
        nx       = '0;
        nx.op    = op;
        nx.cx    = coord_x;
        nx.cy    = coord_y;
        nx.pix   = pixel_in;
        nx.ld_ok = (int'(coord_x) < SOURCE_WIDTH) && (int'(coord_y) < SOURCE_HEIGHT);
        nx.addr  = RW'(coord_x) + RW'(coord_y) * RW'(SOURCE_WIDTH);
        nx.wc    = signed'({1'b0, crop_width_reg}) * cos_reg;
        nx.ws    = signed'({1'b0, crop_width_reg}) * sin_reg;
        nx.hs    = signed'({1'b0, crop_height_reg}) * sin_reg;
        nx.hc    = signed'({1'b0, crop_height_reg}) * cos_reg;
        pipe_next[ST_IN] = nx;

        // find the bounding box corners
        nx = pipe_reg[ST_BOX - 1];
        x2 = -CRN_W'(nx.hs);
        x3 = CRN_W'(nx.wc) + x2;
        y1 = CRN_W'(nx.ws);
        y2 = CRN_W'(nx.hc);
        y3 = y1 + y2;
        nx.min_x = min2(min2('0, CRN_W'(nx.wc)), min2(x2, x3));
        nx.max_x = max2(max2('0, CRN_W'(nx.wc)), max2(x2, x3));
        nx.min_y = min2(min2('0, y1), min2(y2, y3));
        nx.max_y = max2(max2('0, y1), max2(y2, y3));
        pipe_next[ST_BOX] = nx;

        // size the box and offset the destination point
        nx     = pipe_reg[ST_SIZE - 1];
        span_x = (CRN_W + 1)'(nx.max_x) - (CRN_W + 1)'(nx.min_x);
        span_y = (CRN_W + 1)'(nx.max_y) - (CRN_W + 1)'(nx.min_y);
        ceil_x = (span_x + CEIL_BIAS) >> Q14_FRAC;
        ceil_y = (span_y + CEIL_BIAS) >> Q14_FRAC;
        nx.rw  = (ceil_x > (CRN_W + 1)'(BOX_MAX)) ? BOX_MAX : ceil_x[SIZE_W-1:0];
        nx.rh  = (ceil_y > (CRN_W + 1)'(BOX_MAX)) ? BOX_MAX : ceil_y[SIZE_W-1:0];
        nx.pos_x = CRN_W'(signed'({1'b0, nx.cx, {Q14_FRAC{1'b0}}})) + nx.min_x;
        nx.pos_y = CRN_W'(signed'({1'b0, nx.cy, {Q14_FRAC{1'b0}}})) + nx.min_y;
        pipe_next[ST_SIZE] = nx;

        // rotate back: four products, and test the point against the box
        nx       = pipe_reg[ST_MUL - 1];
        nx.inbox = ({1'b0, nx.cx} < nx.rw) && ({1'b0, nx.cy} < nx.rh);
        nx.xc    = PRD_W'(nx.pos_x) * PRD_W'(cos_reg);
        nx.ys    = PRD_W'(nx.pos_y) * PRD_W'(sin_reg);
        nx.yc    = PRD_W'(nx.pos_y) * PRD_W'(cos_reg);
        nx.xs    = PRD_W'(nx.pos_x) * PRD_W'(sin_reg);
        pipe_next[ST_MUL] = nx;

        // combine the products
        nx       = pipe_reg[ST_SUM - 1];
        nx.num_x = SUM_W'(nx.xc) + SUM_W'(nx.ys);
        nx.num_y = SUM_W'(nx.yc) - SUM_W'(nx.xs);
        pipe_next[ST_SUM] = nx;

        // scale down, truncating toward zero
        nx       = pipe_reg[ST_DIV - 1];
        bias_x   = nx.num_x + (nx.num_x[SUM_W-1] ? TRUNC_BIAS : '0);
        bias_y   = nx.num_y + (nx.num_y[SUM_W-1] ? TRUNC_BIAS : '0);
        nx.src_x = bias_x[SUM_W-1:Q28_FRAC];
        nx.src_y = bias_y[SUM_W-1:Q28_FRAC];
        pipe_next[ST_DIV] = nx;

        // check the crop region and offset into the store
        nx         = pipe_reg[ST_CHK - 1];
        nx.in_crop = nx.inbox
                  && !nx.src_x[SRC_W-1]
                  && (nx.src_x[SRC_W-2:0] < (SRC_W - 1)'(crop_width_reg))
                  && !nx.src_y[SRC_W-1]
                  && (nx.src_y[SRC_W-2:0] < (SRC_W - 1)'(crop_height_reg));
        nx.col     = SIZE_W'(crop_left_reg) + SIZE_W'(nx.src_x[CROP_DIM_W-1:0]);
        nx.row     = SIZE_W'(crop_top_reg) + SIZE_W'(nx.src_y[CROP_DIM_W-1:0]);
        pipe_next[ST_CHK] = nx;

        // form the linear address of a query; loads keep theirs
        nx = pipe_reg[ST_ADDR - 1];
        if (nx.op == OP_QUERY)
        begin
            nx.addr = RW'(nx.col) + RW'(nx.row) * RW'(SOURCE_WIDTH);
        end
        pipe_next[ST_ADDR] = nx;

        // wrap the address into the store, largest multiple first
        for (int j = 0; j < RED_STEPS; j++)
        begin
            nx      = pipe_reg[ST_RED0 + j - 1];
            red_sub = RW'(STORE_DEPTH) << (RED_STEPS - 1 - j);
            if (nx.addr >= red_sub)
            begin
                nx.addr = nx.addr - red_sub;
            end
            pipe_next[ST_RED0 + j] = nx;
        end

        // output stage holds the result fields
        pipe_next[ST_LAST] = pipe_reg[ST_LAST - 1];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_ST; k++)
        begin
            if (stage_en[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // Write loads and read queries as they move into the output stage
    assign mem_move = stage_en[ST_LAST] && valid_reg[ST_LAST - 1];

    always_ff @(posedge clk)
    begin
        if (mem_move)
        begin
            if (pipe_reg[ST_LAST - 1].op == OP_LOAD)
            begin
                if (pipe_reg[ST_LAST - 1].ld_ok)
                begin
                    store_mem[pipe_reg[ST_LAST - 1].addr[AW-1:0]] <= pipe_reg[ST_LAST - 1].pix;
                end
            end
            else
            begin
                rd_data_reg <= store_mem[pipe_reg[ST_LAST - 1].addr[AW-1:0]];
            end
        end
    end

    // Drive the result
    assign out_valid      = valid_reg[ST_LAST];
    assign pixel_out      = pipe_reg[ST_LAST].in_crop ? rd_data_reg : FILL_PIXEL;
    assign inside_res     = pipe_reg[ST_LAST].in_crop;
    assign rotated_width  = pipe_reg[ST_LAST].rw;
    assign rotated_height = pipe_reg[ST_LAST].rh;

`ifndef SYNTHESIS
    // a sample inside the crop region implies a non-empty box
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> (rotated_width != '0) && (rotated_height != '0))
        else $error("inside result with an empty bounding box");

    // box size saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rotated_width <= BOX_MAX) && (rotated_height <= BOX_MAX))
        else $error("bounding box size above saturation limit");

    // input is refused only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> &valid_reg)
        else $error("input stalled while a stage is empty");

    // wrapped address lies in the store
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_LAST - 1] |-> (pipe_reg[ST_LAST - 1].addr < RW'(STORE_DEPTH)))
        else $error("store address beyond depth after wrapping");

    // a held stage before the output stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_LAST - 1] && !stage_en[ST_LAST - 1] |=> valid_reg[ST_LAST - 1])
        else $error("stalled item lost before the store stage");
`endif

endmodule
